/* hdl/i2cm_pkg.sv */
// Shared types and constants for the I2C master transaction engine.
// Used by i2cm_cfg, i2cm_core, the top level and the testbench; depends on nothing else.
`default_nettype none

package i2cm_pkg;

  // Register indexes of the configuration port.
  localparam logic REG_HALF_PERIOD = 1'b0;
  localparam logic REG_ACK_TIMEOUT = 1'b1;

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd10;
  localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd1000;

  // Transaction codes carried in the op field.
  localparam logic [2:0] OP_PROBE     = 3'd0;
  localparam logic [2:0] OP_WRITE     = 3'd1;
  localparam logic [2:0] OP_READ      = 3'd2;
  localparam logic [2:0] OP_REG_WRITE = 3'd3;
  localparam logic [2:0] OP_REG_READ  = 3'd4;

  localparam logic [7:0] ADDR_DIR_MASK = 8'hFE;
  localparam logic [7:0] ADDR_DIR_READ = 8'h01;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;
  localparam logic [3:0] LAST_BIT      = 4'd7;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_START_A = 5'd1,
    PH_START_B = 5'd2,
    PH_BIT_A   = 5'd3,
    PH_BIT_B   = 5'd4,
    PH_BIT_C   = 5'd5,
    PH_ACK_A   = 5'd6,
    PH_ACK_B   = 5'd7,
    PH_POLL    = 5'd8,
    PH_RD_A    = 5'd9,
    PH_RD_B    = 5'd10,
    PH_RA_A    = 5'd11,
    PH_RA_B    = 5'd12,
    PH_RA_C    = 5'd13,
    PH_STOP_A  = 5'd14,
    PH_STOP_B  = 5'd15,
    PH_STOP_C  = 5'd16
  } phase_e;

  typedef enum logic [2:0] {
    ST_ADDR_W = 3'd0,
    ST_MEM_HI = 3'd1,
    ST_MEM_LO = 3'd2,
    ST_TX     = 3'd3,
    ST_ADDR_R = 3'd4,
    ST_RX     = 3'd5
  } stage_e;

  typedef struct packed {
    logic [15:0] half_period_ticks;
    logic [15:0] ack_timeout;
  } cfg_t;

  typedef struct packed {
    logic        cmd;
    logic [2:0]  op;
    logic [7:0]  dev_address;
    logic [15:0] mem_address;
    logic        mem_addr_two_bytes;
    logic [15:0] length;
    logic [7:0]  tx_byte;
    logic        sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       tx_taken;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       busy_res;
    logic       done_res;
    logic       status;
  } out_item_t;

endpackage

`default_nettype wire

/* hdl/i2cm_cfg.sv */
// Configuration registers of the I2C master: bus delay and acknowledge timeout.
// Depends on i2cm_pkg.
`default_nettype none

module i2cm_cfg import i2cm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        wr_en_i,
  input  wire logic        wr_index_i,
  input  wire logic [15:0] wr_data_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        REG_HALF_PERIOD: cfg_d.half_period_ticks = wr_data_i;
        REG_ACK_TIMEOUT: cfg_d.ack_timeout       = wr_data_i;
        default:         cfg_d                   = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period_ticks <= HALF_PERIOD_RESET;
      cfg_q.ack_timeout       <= ACK_TIMEOUT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* hdl/i2cm_core.sv */
// Bus sequencer of the I2C master: transaction state and the per-word step logic.
// Depends on i2cm_pkg; the state advances only when en_i is high.
`default_nettype none

module i2cm_core import i2cm_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     en_i,
  input  wire in_item_t item_i,
  input  wire cfg_t     cfg_i,
  output out_item_t     res_o
);

  localparam int CW = COUNT_WIDTH;

  phase_e          phase_q, phase_d;
  stage_e          stage_q, stage_d;
  logic [CW-1:0]   delay_q, delay_d;
  logic [CW-1:0]   wait_q, wait_d;
  logic [3:0]      bit_q, bit_d;
  logic [7:0]      shift_q, shift_d;
  logic [15:0]     byte_q, byte_d;
  logic [15:0]     trial_q, trial_d;
  logic [2:0]      op_q, op_d;
  logic [7:0]      dev_q, dev_d;
  logic [15:0]     mem_q, mem_d;
  logic            wide_q, wide_d;
  logic [15:0]     length_q, length_d;
  logic            scl_q, scl_d;
  logic            sda_q, sda_d;
  logic            failed_q, failed_d;
  logic            stop_round_q, stop_round_d;

  logic [CW-1:0]   hp_cnt, seg_len, ack_cnt, delay_dec, wait_dec;
  logic [3:0]      bit_inc;
  logic [7:0]      rd_shift, tx_shift;
  logic [15:0]     trial_inc;
  logic            last_rd;
  out_item_t       res;

  // A zero half period still gives each segment one tick.
  assign hp_cnt    = CW'(cfg_i.half_period_ticks);
  assign seg_len   = (hp_cnt == '0) ? CW'(1) : hp_cnt;
  assign ack_cnt   = CW'(cfg_i.ack_timeout);
  assign delay_dec = delay_q - CW'(1);
  assign wait_dec  = wait_q - CW'(1);
  assign bit_inc   = bit_q + 4'd1;
  assign rd_shift  = {shift_q[6:0], item_i.sda_in};
  assign tx_shift  = {shift_q[6:0], 1'b0};
  assign trial_inc = trial_q + 16'd1;
  assign last_rd   = (({1'b0, byte_q} + 17'd1) == {1'b0, length_q});

  always_comb begin
    logic       ent;
    phase_e     ent_phase;
    logic       ent_scl;
    logic       ent_sda;
    logic       snd;
    logic [7:0] snd_byte;
    logic       nxt_tx;
    logic       nxt_rx;

    phase_d      = phase_q;
    stage_d      = stage_q;
    delay_d      = delay_q;
    wait_d       = wait_q;
    bit_d        = bit_q;
    shift_d      = shift_q;
    byte_d       = byte_q;
    trial_d      = trial_q;
    op_d         = op_q;
    dev_d        = dev_q;
    mem_d        = mem_q;
    wide_d       = wide_q;
    length_d     = length_q;
    scl_d        = scl_q;
    sda_d        = sda_q;
    failed_d     = failed_q;
    stop_round_d = stop_round_q;
    res          = '0;
    ent          = 1'b0;
    ent_phase    = PH_IDLE;
    ent_scl      = 1'b1;
    ent_sda      = 1'b1;
    snd          = 1'b0;
    snd_byte     = '0;
    nxt_tx       = 1'b0;
    nxt_rx       = 1'b0;

    if (item_i.cmd) begin
      // A begin word while a transaction runs is dropped and takes no time.
      if (phase_q == PH_IDLE) begin
        op_d         = item_i.op;
        dev_d        = item_i.dev_address;
        mem_d        = item_i.mem_address;
        wide_d       = item_i.mem_addr_two_bytes;
        length_d     = item_i.length;
        byte_d       = '0;
        trial_d      = '0;
        failed_d     = 1'b0;
        stop_round_d = 1'b0;
        if ((item_i.op > OP_REG_READ) ||
            ((item_i.op == OP_PROBE) && (item_i.length == '0))) begin
          phase_d      = PH_IDLE;
          res.done_res = 1'b1;
          res.status   = 1'b1;
        end else begin
          stage_d   = (item_i.op == OP_READ) ? ST_ADDR_R : ST_ADDR_W;
          ent       = 1'b1;
          ent_phase = PH_START_A;
        end
      end
    end else if (phase_q == PH_POLL) begin
      if (!item_i.sda_in) begin
        scl_d = 1'b0;
        case (stage_q)
          ST_ADDR_W: begin
            if (op_q == OP_PROBE) begin
              ent       = 1'b1;
              ent_phase = PH_STOP_A;
              ent_scl   = 1'b0;
              ent_sda   = 1'b0;
            end else if (op_q == OP_WRITE) begin
              stage_d = ST_TX;
              nxt_tx  = 1'b1;
            end else if (wide_q) begin
              stage_d  = ST_MEM_HI;
              snd      = 1'b1;
              snd_byte = mem_q[15:8];
            end else begin
              stage_d  = ST_MEM_LO;
              snd      = 1'b1;
              snd_byte = mem_q[7:0];
            end
          end
          ST_MEM_HI: begin
            stage_d  = ST_MEM_LO;
            snd      = 1'b1;
            snd_byte = mem_q[7:0];
          end
          ST_MEM_LO: begin
            if (op_q == OP_REG_WRITE) begin
              stage_d = ST_TX;
              nxt_tx  = 1'b1;
            end else begin
              // Register read turns the bus around with a repeated start.
              stage_d   = ST_ADDR_R;
              ent       = 1'b1;
              ent_phase = PH_START_A;
            end
          end
          ST_TX: nxt_tx = 1'b1;
          ST_ADDR_R: begin
            stage_d = ST_RX;
            nxt_rx  = 1'b1;
          end
          default: begin
            ent       = 1'b1;
            ent_phase = PH_STOP_A;
            ent_scl   = 1'b0;
            ent_sda   = 1'b0;
          end
        endcase
      end else begin
        wait_d = wait_dec;
        if (wait_dec == '0) begin
          failed_d  = 1'b1;
          ent       = 1'b1;
          ent_phase = PH_STOP_A;
          ent_scl   = 1'b1;
          ent_sda   = 1'b0;
        end
      end
    end else if (phase_q != PH_IDLE) begin
      delay_d = delay_dec;
      if (delay_dec == '0) begin
        case (phase_q)
          PH_START_A: begin
            ent = 1'b1; ent_phase = PH_START_B; ent_scl = 1'b1; ent_sda = 1'b0;
          end
          PH_START_B: begin
            snd      = 1'b1;
            snd_byte = (stage_q == ST_ADDR_R) ? ((dev_q & ADDR_DIR_MASK) | ADDR_DIR_READ)
                                              : (dev_q & ADDR_DIR_MASK);
          end
          PH_BIT_A: begin
            ent = 1'b1; ent_phase = PH_BIT_B; ent_scl = 1'b1; ent_sda = sda_q;
          end
          PH_BIT_B: begin
            ent = 1'b1; ent_phase = PH_BIT_C; ent_scl = 1'b0; ent_sda = sda_q;
          end
          PH_BIT_C: begin
            shift_d = tx_shift;
            bit_d   = bit_inc;
            ent     = 1'b1;
            ent_scl = 1'b0;
            if (bit_inc >= BITS_PER_BYTE) begin
              ent_phase = PH_ACK_A;
              ent_sda   = 1'b1;
            end else begin
              ent_phase = PH_BIT_A;
              ent_sda   = tx_shift[7];
            end
          end
          PH_ACK_A: begin
            ent = 1'b1; ent_phase = PH_ACK_B; ent_scl = 1'b1; ent_sda = 1'b1;
          end
          PH_ACK_B: begin
            phase_d = PH_POLL;
            wait_d  = ack_cnt;
          end
          PH_RD_A: begin
            shift_d = rd_shift;
            if (bit_q == LAST_BIT) begin
              res.rx_valid = 1'b1;
              res.rx_byte  = rd_shift;
            end
            ent = 1'b1; ent_phase = PH_RD_B; ent_scl = 1'b0; ent_sda = 1'b1;
          end
          PH_RD_B: begin
            bit_d = bit_inc;
            ent   = 1'b1;
            if (bit_inc >= BITS_PER_BYTE) begin
              // The last byte of the read is answered with a NACK.
              ent_phase = PH_RA_A;
              ent_scl   = 1'b0;
              ent_sda   = last_rd;
            end else begin
              ent_phase = PH_RD_A;
              ent_scl   = 1'b1;
              ent_sda   = 1'b1;
            end
          end
          PH_RA_A: begin
            ent = 1'b1; ent_phase = PH_RA_B; ent_scl = 1'b1; ent_sda = sda_q;
          end
          PH_RA_B: begin
            ent = 1'b1; ent_phase = PH_RA_C; ent_scl = 1'b0; ent_sda = sda_q;
          end
          PH_RA_C: begin
            byte_d = byte_q + 16'd1;
            nxt_rx = 1'b1;
          end
          PH_STOP_A: begin
            ent = 1'b1; ent_phase = PH_STOP_B; ent_scl = 1'b1; ent_sda = 1'b0;
          end
          PH_STOP_B: begin
            ent = 1'b1; ent_phase = PH_STOP_C; ent_scl = 1'b1; ent_sda = 1'b1;
          end
          PH_STOP_C: begin
            if ((op_q == OP_PROBE) && failed_q) begin
              // A failed probe trial sends a second stop, then retries or ends the transaction.
              if (!stop_round_q) begin
                stop_round_d = 1'b1;
                ent          = 1'b1;
                ent_phase    = PH_STOP_A;
                ent_scl      = scl_q;
                ent_sda      = 1'b0;
              end else begin
                trial_d = trial_inc;
                if (trial_inc < length_q) begin
                  failed_d     = 1'b0;
                  stop_round_d = 1'b0;
                  stage_d      = ST_ADDR_W;
                  ent          = 1'b1;
                  ent_phase    = PH_START_A;
                end else begin
                  phase_d      = PH_IDLE;
                  res.done_res = 1'b1;
                  res.status   = 1'b1;
                end
              end
            end else begin
              phase_d      = PH_IDLE;
              res.done_res = 1'b1;
              res.status   = failed_q;
            end
          end
          default: begin
            phase_d      = PH_IDLE;
            res.done_res = 1'b1;
            res.status   = 1'b1;
          end
        endcase
      end
    end

    if (nxt_tx) begin
      if (byte_d >= length_q) begin
        ent = 1'b1; ent_phase = PH_STOP_A; ent_scl = 1'b0; ent_sda = 1'b0;
      end else begin
        snd          = 1'b1;
        snd_byte     = item_i.tx_byte;
        res.tx_taken = 1'b1;
        byte_d       = byte_d + 16'd1;
      end
    end

    if (nxt_rx) begin
      if (byte_d >= length_q) begin
        ent = 1'b1; ent_phase = PH_STOP_A; ent_scl = 1'b0; ent_sda = 1'b0;
      end else begin
        shift_d = '0;
        bit_d   = '0;
        ent = 1'b1; ent_phase = PH_RD_A; ent_scl = 1'b1; ent_sda = 1'b1;
      end
    end

    if (snd) begin
      shift_d   = snd_byte;
      bit_d     = '0;
      ent       = 1'b1;
      ent_phase = PH_BIT_A;
      ent_scl   = 1'b0;
      ent_sda   = snd_byte[7];
    end

    if (ent) begin
      phase_d = ent_phase;
      scl_d   = ent_scl;
      sda_d   = ent_sda;
      delay_d = seg_len;
    end

    res.scl_out  = scl_d;
    res.sda_out  = sda_d;
    res.busy_res = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      stage_q      <= ST_ADDR_W;
      delay_q      <= '0;
      wait_q       <= '0;
      bit_q        <= '0;
      shift_q      <= '0;
      byte_q       <= '0;
      trial_q      <= '0;
      op_q         <= '0;
      dev_q        <= '0;
      mem_q        <= '0;
      wide_q       <= 1'b0;
      length_q     <= '0;
      scl_q        <= 1'b1;
      sda_q        <= 1'b1;
      failed_q     <= 1'b0;
      stop_round_q <= 1'b0;
    end else if (en_i) begin
      phase_q      <= phase_d;
      stage_q      <= stage_d;
      delay_q      <= delay_d;
      wait_q       <= wait_d;
      bit_q        <= bit_d;
      shift_q      <= shift_d;
      byte_q       <= byte_d;
      trial_q      <= trial_d;
      op_q         <= op_d;
      dev_q        <= dev_d;
      mem_q        <= mem_d;
      wide_q       <= wide_d;
      length_q     <= length_d;
      scl_q        <= scl_d;
      sda_q        <= sda_d;
      failed_q     <= failed_d;
      stop_round_q <= stop_round_d;
    end
  end

  assign res_o = res;

endmodule

`default_nettype wire

/* hdl/i2c_master_transaction_engine.sv */
// I2C master transaction engine: input word register, bus sequencer, result register.
// A word accepted into the input word register is processed once the result register is
// free, and its result then enters the result register. Throughput: one word per clock
// while out_stall_i does not hold the result register; the sequencer steps once per word.
// Reset (asynchronous, active low) idles the sequencer, releases SCL and SDA,
// empties both registers and loads a half period of 10 and an ack timeout of 1000.
`default_nettype none

module i2c_master_transaction_engine import i2cm_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_item_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_item_t        out_data_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  cfg_t      cfg;
  in_item_t  s1_data_q;
  logic      s1_valid_q, s1_valid_d;
  out_item_t out_data_q, step_res;
  logic      out_valid_q;
  logic      out_load, step_en, in_fire;

  assign cfg_ready_o = 1'b1;

  i2cm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // The result register frees up when it is empty or its word leaves this cycle.
  assign out_load   = !out_valid_q || !out_stall_i;
  assign step_en    = s1_valid_q && out_load;
  assign in_stall_o = s1_valid_q && !out_load;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (step_en) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (out_load) begin
        out_valid_q <= step_en;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_data_q <= in_data_i;
    end
    if (step_en) begin
      out_data_q <= step_res;
    end
  end

  i2cm_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (step_en),
    .item_i (s1_data_q),
    .cfg_i  (cfg),
    .res_o  (step_res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with an empty word register");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.done_res && out_data_o.busy_res))
    else $error("transaction reported done while still busy");

  a_status_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status) |-> out_data_o.done_res)
    else $error("status raised without done");

  a_rx_scl_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.rx_valid) |-> (out_data_o.busy_res && !out_data_o.scl_out))
    else $error("read word completed outside a low SCL phase");

endmodule

`default_nettype wire

/* verif/tb_i2c_master_transaction_engine.sv */
// Testbench for the I2C master transaction engine: drives begin and tick words, acts as the
// bus device on SDA, predicts every result word and compares it with the block's output.
// Depends on i2cm_pkg and i2c_master_transaction_engine.
`default_nettype none

module tb_i2c_master_transaction_engine;
  import i2cm_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int ALL_ACKS    = 1000;
  localparam int RANDOM_WORDS_PER_SETTING = 190;

  typedef enum int {RX_TAKE_ALL, RX_SPARSE, RX_TOGGLE, RX_HEAVY} rx_pace_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [15:0] cfg_data_i;

  i2c_master_transaction_engine DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted engine state, kept in step with every accepted word.
  logic [15:0] cfg_half;
  logic [15:0] cfg_ack;
  phase_e      ph;
  stage_e      stg;
  logic [15:0] dly;
  logic [3:0]  nbit;
  logic [7:0]  shreg;
  logic [15:0] nbyte;
  logic [15:0] wcnt;
  logic [15:0] ntrial;
  logic [2:0]  h_op;
  logic [7:0]  h_dev;
  logic [15:0] h_mem;
  logic        h_wide;
  logic [15:0] h_len;
  logic        scl_q;
  logic        sda_q;
  logic        failed_q;
  logic        stop_round_q;
  out_item_t   engine_out;

  out_item_t   engine_results_due[$];
  out_item_t   want;
  int          mismatches = 0;
  int          cycle_count = 0;
  int          words_done = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b1;
  bit          quiet_rx = 1'b0;
  logic [7:0]  tx_hold;
  rx_pace_e    pace = RX_TAKE_ALL;
  int          pace_left = 0;

  function automatic void enter_segment(input phase_e p, input logic scl, input logic sda);
    ph = p;
    scl_q = scl;
    sda_q = sda;
    dly = (cfg_half == 16'd0) ? 16'd1 : cfg_half;
  endfunction

  function automatic void load_byte(input logic [7:0] b);
    shreg = b;
    nbit = 4'd0;
    enter_segment(PH_BIT_A, 1'b0, b[7]);
  endfunction

  function automatic void end_txn(input logic st);
    ph = PH_IDLE;
    engine_out.done_res = 1'b1;
    engine_out.status = st;
  endfunction

  function automatic void next_write_byte(input logic [7:0] tx);
    if (nbyte >= h_len) begin
      enter_segment(PH_STOP_A, 1'b0, 1'b0);
    end else begin
      load_byte(tx);
      engine_out.tx_taken = 1'b1;
      nbyte = nbyte + 16'd1;
    end
  endfunction

  function automatic void next_read_byte();
    if (nbyte >= h_len) begin
      enter_segment(PH_STOP_A, 1'b0, 1'b0);
    end else begin
      shreg = 8'd0;
      nbit = 4'd0;
      enter_segment(PH_RD_A, 1'b1, 1'b1);
    end
  endfunction

  function automatic void advance_engine(input in_item_t w);
    engine_out = '0;
    if (w.cmd) begin
      // A begin word while a transaction runs is dropped without consuming time.
      if (ph == PH_IDLE) begin
        h_op = w.op;
        h_dev = w.dev_address;
        h_mem = w.mem_address;
        h_wide = w.mem_addr_two_bytes;
        h_len = w.length;
        nbyte = 16'd0;
        ntrial = 16'd0;
        failed_q = 1'b0;
        stop_round_q = 1'b0;
        if (w.op > OP_REG_READ || (w.op == OP_PROBE && w.length == 16'd0)) begin
          end_txn(1'b1);
        end else begin
          stg = (w.op == OP_READ) ? ST_ADDR_R : ST_ADDR_W;
          enter_segment(PH_START_A, 1'b1, 1'b1);
        end
      end
    end else if (ph == PH_POLL) begin
      if (!w.sda_in) begin
        scl_q = 1'b0;
        case (stg)
          ST_ADDR_W: begin
            if (h_op == OP_PROBE) begin
              enter_segment(PH_STOP_A, 1'b0, 1'b0);
            end else if (h_op == OP_WRITE) begin
              stg = ST_TX;
              next_write_byte(w.tx_byte);
            end else if (h_wide) begin
              stg = ST_MEM_HI;
              load_byte(h_mem[15:8]);
            end else begin
              stg = ST_MEM_LO;
              load_byte(h_mem[7:0]);
            end
          end
          ST_MEM_HI: begin
            stg = ST_MEM_LO;
            load_byte(h_mem[7:0]);
          end
          ST_MEM_LO: begin
            if (h_op == OP_REG_WRITE) begin
              stg = ST_TX;
              next_write_byte(w.tx_byte);
            end else begin
              stg = ST_ADDR_R;
              enter_segment(PH_START_A, 1'b1, 1'b1);
            end
          end
          ST_TX: next_write_byte(w.tx_byte);
          ST_ADDR_R: begin
            stg = ST_RX;
            next_read_byte();
          end
          default: enter_segment(PH_STOP_A, 1'b0, 1'b0);
        endcase
      end else begin
        wcnt = wcnt - 16'd1;
        if (wcnt == 16'd0) begin
          failed_q = 1'b1;
          enter_segment(PH_STOP_A, 1'b1, 1'b0);
        end
      end
    end else if (ph != PH_IDLE) begin
      dly = dly - 16'd1;
      if (dly == 16'd0) begin
        case (ph)
          PH_START_A: enter_segment(PH_START_B, 1'b1, 1'b0);
          PH_START_B: begin
            load_byte((stg == ST_ADDR_R) ? ((h_dev & ADDR_DIR_MASK) | ADDR_DIR_READ)
                                         : (h_dev & ADDR_DIR_MASK));
          end
          PH_BIT_A: enter_segment(PH_BIT_B, 1'b1, sda_q);
          PH_BIT_B: enter_segment(PH_BIT_C, 1'b0, sda_q);
          PH_BIT_C: begin
            shreg = shreg << 1;
            nbit = nbit + 4'd1;
            if (nbit >= BITS_PER_BYTE) begin
              enter_segment(PH_ACK_A, 1'b0, 1'b1);
            end else begin
              enter_segment(PH_BIT_A, 1'b0, shreg[7]);
            end
          end
          PH_ACK_A: enter_segment(PH_ACK_B, 1'b1, 1'b1);
          PH_ACK_B: begin
            ph = PH_POLL;
            wcnt = cfg_ack;
          end
          PH_RD_A: begin
            shreg = {shreg[6:0], w.sda_in};
            if (nbit == LAST_BIT) begin
              engine_out.rx_valid = 1'b1;
              engine_out.rx_byte = shreg;
            end
            enter_segment(PH_RD_B, 1'b0, 1'b1);
          end
          PH_RD_B: begin
            nbit = nbit + 4'd1;
            if (nbit >= BITS_PER_BYTE) begin
              // The last byte of the read gets a NACK, all others an ACK.
              enter_segment(PH_RA_A, 1'b0, ({1'b0, nbyte} + 17'd1) == {1'b0, h_len});
            end else begin
              enter_segment(PH_RD_A, 1'b1, 1'b1);
            end
          end
          PH_RA_A: enter_segment(PH_RA_B, 1'b1, sda_q);
          PH_RA_B: enter_segment(PH_RA_C, 1'b0, sda_q);
          PH_RA_C: begin
            nbyte = nbyte + 16'd1;
            next_read_byte();
          end
          PH_STOP_A: enter_segment(PH_STOP_B, 1'b1, 1'b0);
          PH_STOP_B: enter_segment(PH_STOP_C, 1'b1, 1'b1);
          PH_STOP_C: begin
            // A failed probe trial gets a second stop, then the next trial or the end.
            if (h_op == OP_PROBE && failed_q) begin
              if (!stop_round_q) begin
                stop_round_q = 1'b1;
                enter_segment(PH_STOP_A, scl_q, 1'b0);
              end else begin
                ntrial = ntrial + 16'd1;
                if (ntrial < h_len) begin
                  failed_q = 1'b0;
                  stop_round_q = 1'b0;
                  stg = ST_ADDR_W;
                  enter_segment(PH_START_A, 1'b1, 1'b1);
                end else begin
                  end_txn(1'b1);
                end
              end
            end else begin
              end_txn(failed_q);
            end
          end
          default: end_txn(1'b1);
        endcase
      end
    end
    engine_out.scl_out = scl_q;
    engine_out.sda_out = sda_q;
    engine_out.busy_res = (ph != PH_IDLE);
  endfunction

  function automatic in_item_t random_word();
    logic [63:0] r;
    in_item_t w;
    r = {$urandom, $urandom};
    w = r[53:0];
    return w;
  endfunction

  function automatic in_item_t begin_word(input logic [2:0] op, input logic [7:0] dev,
                                          input logic [15:0] mem, input logic wide,
                                          input logic [15:0] len);
    in_item_t w;
    w = random_word();
    w.cmd = 1'b1;
    w.op = op;
    w.dev_address = dev;
    w.mem_address = mem;
    w.mem_addr_two_bytes = wide;
    w.length = len;
    return w;
  endfunction

  task automatic send_word(input in_item_t w);
    if (gaps_on && burst_left <= 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    burst_left--;
    if (!(w.cmd && ph != PH_IDLE)) words_done++;
    advance_engine(w);
    engine_results_due.push_back(engine_out);
  endtask

  task automatic idle_ticks(input int n);
    in_item_t w;
    repeat (n) begin
      w = random_word();
      w.cmd = 1'b0;
      send_word(w);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (engine_results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Plays the device side: for acknowledge polls of a probe the first `lead` polls are
  // refused, for every other transaction only the first `lead` polls are granted.
  task automatic run_transaction(input in_item_t opening, input int lead, input bit poke);
    in_item_t w;
    int polls;
    int hold;
    bit in_poll;
    bit give_ack;
    send_word(opening);
    polls = 0;
    hold = 0;
    in_poll = 1'b0;
    give_ack = 1'b0;
    while (ph != PH_IDLE) begin
      w = random_word();
      w.cmd = poke || ($urandom_range(0, 47) == 0);
      poke = 1'b0;
      w.tx_byte = tx_hold;
      if (ph == PH_POLL) begin
        if (!in_poll) begin
          give_ack = (opening.op == OP_PROBE) ? (polls >= lead) : (polls < lead);
          hold = $urandom_range(0, 3);
          polls++;
        end
        w.sda_in = !(give_ack && hold == 0);
        if (hold > 0) hold--;
      end
      in_poll = (ph == PH_POLL);
      send_word(w);
      if (engine_out.tx_taken) tx_hold = $urandom_range(0, 255);
    end
  endtask

  task automatic load_timing(input logic [15:0] half, input logic [15:0] ack);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_HALF_PERIOD;
    cfg_data_i <= half;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_half = half;
    cfg_index_i <= REG_ACK_TIMEOUT;
    cfg_data_i <= ack;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_ack = ack;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_reset_timing();
    idle_ticks(3);
    run_transaction(begin_word(3'd7, 8'h5A, 16'h1234, 1'b0, 16'd1), ALL_ACKS, 1'b0);
    run_transaction(begin_word(OP_PROBE, 8'hA1, 16'h0000, 1'b0, 16'd1), 0, 1'b0);
    // One refused probe waits out the full reset timeout.
    run_transaction(begin_word(OP_PROBE, 8'h3C, 16'h0000, 1'b0, 16'd1), 1, 1'b0);
  endtask

  task automatic test_operations();
    load_timing(16'd1, 16'd4);
    run_transaction(begin_word(OP_PROBE, 8'hFF, 16'h0000, 1'b0, 16'd2), 1, 1'b0);
    run_transaction(begin_word(OP_PROBE, 8'h00, 16'hFFFF, 1'b1, 16'd3), 3, 1'b0);
    run_transaction(begin_word(OP_WRITE, 8'h00, 16'h0000, 1'b0, 16'd0), ALL_ACKS, 1'b0);
    run_transaction(begin_word(OP_WRITE, 8'hFF, 16'hFFFF, 1'b1, 16'd2), ALL_ACKS, 1'b1);
    run_transaction(begin_word(OP_WRITE, 8'h42, 16'h0F0F, 1'b0, 16'hFFFF), 2, 1'b0);
    run_transaction(begin_word(OP_WRITE, 8'h42, 16'h0F0F, 1'b0, 16'd1), 0, 1'b0);
    run_transaction(begin_word(OP_READ, 8'h00, 16'h0000, 1'b0, 16'd0), ALL_ACKS, 1'b0);
    run_transaction(begin_word(OP_READ, 8'hFF, 16'h8001, 1'b1, 16'd3), ALL_ACKS, 1'b0);
    run_transaction(begin_word(OP_READ, 8'h81, 16'h0000, 1'b0, 16'hFFFF), 0, 1'b0);
    run_transaction(begin_word(OP_REG_WRITE, 8'hA0, 16'hFFFF, 1'b1, 16'd1), ALL_ACKS, 1'b0);
    run_transaction(begin_word(OP_REG_WRITE, 8'hA0, 16'h0000, 1'b0, 16'd2), ALL_ACKS, 1'b0);
    run_transaction(begin_word(OP_REG_READ, 8'hA1, 16'hA5C3, 1'b1, 16'd2), ALL_ACKS, 1'b0);
    run_transaction(begin_word(OP_REG_READ, 8'h7E, 16'hFFFF, 1'b0, 16'd1), ALL_ACKS, 1'b1);
    run_transaction(begin_word(3'd5, 8'h10, 16'h0000, 1'b0, 16'd4), ALL_ACKS, 1'b0);
    run_transaction(begin_word(3'd6, 8'h10, 16'h0000, 1'b1, 16'd4), ALL_ACKS, 1'b0);
    run_transaction(begin_word(OP_PROBE, 8'h10, 16'h0000, 1'b0, 16'd0), ALL_ACKS, 1'b0);
  endtask

  task automatic test_timing_extremes();
    load_timing(16'd0, 16'd1);
    run_transaction(begin_word(OP_WRITE, 8'h3A, 16'h0000, 1'b0, 16'd2), ALL_ACKS, 1'b0);
    run_transaction(begin_word(OP_READ, 8'h3B, 16'h0000, 1'b0, 16'd1), ALL_ACKS, 1'b0);
    run_transaction(begin_word(OP_PROBE, 8'h3C, 16'h0000, 1'b0, 16'd2), 1, 1'b0);
    // The longest delay is only visited with words that end at once.
    load_timing(16'hFFFF, 16'hFFFF);
    idle_ticks(2);
    run_transaction(begin_word(3'd7, 8'hFF, 16'hFFFF, 1'b1, 16'hFFFF), ALL_ACKS, 1'b0);
    run_transaction(begin_word(OP_PROBE, 8'hFF, 16'hFFFF, 1'b1, 16'd0), ALL_ACKS, 1'b0);
    load_timing(16'd1, 16'hFFFF);
    run_transaction(begin_word(OP_WRITE, 8'h55, 16'h0000, 1'b0, 16'd1), ALL_ACKS, 1'b0);
  endtask

  task automatic test_ack_wait_wrap();
    // A zero timeout lets SDA stay high for the full count range before the stop.
    load_timing(16'd0, 16'd0);
    gaps_on = 1'b0;
    quiet_rx = 1'b1;
    run_transaction(begin_word(OP_WRITE, 8'h6E, 16'h0000, 1'b0, 16'd1), 0, 1'b0);
    drain_results();
    gaps_on = 1'b1;
    quiet_rx = 1'b0;
  endtask

  task automatic test_random();
    logic [15:0] halves[4];
    logic [15:0] acks[4];
    logic [2:0]  op;
    logic [15:0] len;
    int          lead;
    int          mark;
    halves = '{16'd1, 16'd0, 16'd2, 16'd3};
    acks   = '{16'd3, 16'd1, 16'd6, 16'd2};
    for (int s = 0; s < 4; s++) begin
      load_timing(halves[s], acks[s]);
      mark = words_done;
      while (words_done - mark < RANDOM_WORDS_PER_SETTING) begin
        gaps_on = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 3) == 0) idle_ticks($urandom_range(1, 3));
        if ($urandom_range(0, 11) == 0) drain_results();
        op = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        len = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 3))
                                         : 16'($urandom_range(0, 65535));
        // Long transfers are cut short by refusing an acknowledge early on.
        if (len <= 16'd3 && op != OP_PROBE) begin
          lead = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : ALL_ACKS;
        end else begin
          case (op)
            OP_PROBE:    lead = $urandom_range(0, 3);
            OP_READ:     lead = 0;
            OP_REG_READ: lead = $urandom_range(0, 2);
            default:     lead = $urandom_range(0, 4);
          endcase
        end
        run_transaction(begin_word(op, 8'($urandom), 16'($urandom), 1'($urandom), len),
                        lead, 1'b0);
      end
    end
    gaps_on = 1'b1;
  endtask

  task automatic check_field(input string name, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (engine_results_due.size() == 0) begin
        $error("result word with nothing expected");
        mismatches++;
      end else begin
        want = engine_results_due.pop_front();
        check_field("scl_out", want.scl_out, out_data_o.scl_out);
        check_field("sda_out", want.sda_out, out_data_o.sda_out);
        check_field("tx_taken", want.tx_taken, out_data_o.tx_taken);
        check_field("rx_byte", want.rx_byte, out_data_o.rx_byte);
        check_field("rx_valid", want.rx_valid, out_data_o.rx_valid);
        check_field("busy_res", want.busy_res, out_data_o.busy_res);
        check_field("done_res", want.done_res, out_data_o.done_res);
        check_field("status", want.status, out_data_o.status);
      end
    end
  end

  // The result side picks a new random stall pattern whenever its pattern counter runs out.
  always @(posedge clk_i) begin
    if (pace_left == 0) begin
      pace = rx_pace_e'($urandom_range(0, 3));
      pace_left = $urandom_range(16, 128);
    end else begin
      pace_left--;
    end
    if (quiet_rx) begin
      out_stall_i <= 1'b0;
    end else begin
      case (pace)
        RX_TAKE_ALL: out_stall_i <= 1'b0;
        RX_SPARSE:   out_stall_i <= ($urandom_range(0, 3) == 0);
        RX_TOGGLE:   out_stall_i <= ~out_stall_i;
        default:     out_stall_i <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_i2c_master_transaction_engine: errors");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_HALF_PERIOD;
    cfg_data_i = 16'd0;
    tx_hold = 8'($urandom);
    cfg_half = HALF_PERIOD_RESET;
    cfg_ack = ACK_TIMEOUT_RESET;
    ph = PH_IDLE;
    stg = ST_ADDR_W;
    dly = 16'd0;
    nbit = 4'd0;
    shreg = 8'd0;
    nbyte = 16'd0;
    wcnt = 16'd0;
    ntrial = 16'd0;
    h_op = 3'd0;
    h_dev = 8'd0;
    h_mem = 16'd0;
    h_wide = 1'b0;
    h_len = 16'd0;
    scl_q = 1'b1;
    sda_q = 1'b1;
    failed_q = 1'b0;
    stop_round_q = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_timing();
    test_operations();
    test_timing_extremes();
    test_ack_wait_wrap();
    test_random();
    drain_results();
    if (mismatches == 0) begin
      $display("tb_i2c_master_transaction_engine: clean");
    end else begin
      $display("tb_i2c_master_transaction_engine: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
hdl/i2cm_pkg.sv
hdl/i2cm_cfg.sv
hdl/i2cm_core.sv
hdl/i2c_master_transaction_engine.sv
verif/tb_i2c_master_transaction_engine.sv
